FILE: sv/lcdnw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared constants, types and tables for the LCD nibble writer
// Command codes, queue sizing, job descriptor and the display init table.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

   // Display geometry
   localparam int LINE_LENGTH = 16;
   localparam int COL_W       = 6;

   // Front/back queue sizing
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command codes on the request channel
   localparam logic [1:0] CMD_WRITE_CHAR = 2'd0;
   localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
   localparam logic [1:0] CMD_RAW        = 2'd2;
   localparam logic [1:0] CMD_INIT       = 2'd3;

   // Line selectors for set cursor
   localparam logic [1:0] LINE_SEL_1 = 2'd1;
   localparam logic [1:0] LINE_SEL_2 = 2'd2;

   // DDRAM base addresses
   localparam logic [7:0] ADDR_LINE1 = 8'h80;
   localparam logic [7:0] ADDR_LINE2 = 8'hC0;

   // Sequencing: six port bytes per display byte, up to seven display bytes
   localparam int INIT_LEN    = 7;
   localparam int BIDX_W      = 3;
   localparam int PHASE_W     = 3;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_HALF  = 3;

   typedef enum logic [1:0] {
      JOB_BYTE,
      JOB_WRAP,
      JOB_INIT
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   value;
      logic         rs;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] init_byte(logic [BIDX_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h32;
         3'd2:    b = 8'h06;
         3'd3:    b = 8'h0C;
         3'd4:    b = 8'h28;
         3'd5:    b = 8'h01;
         3'd6:    b = 8'h02;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: sv/lcdnw_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_ifs: valid/ready channel interfaces
// Request channel carries commands, response channel carries port bytes.
// ----------------------------------------------------------------------------
interface lcdnw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;
   logic [1:0] target_line;
   logic [5:0] target_column;

   modport source (output valid, output command, output data_byte,
                   output target_line, output target_column, input ready);
   modport sink   (input valid, input command, input data_byte,
                   input target_line, input target_column, output ready);
endinterface

interface lcdnw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] port_byte;
   logic       last_of_run;

   modport source (output valid, output port_byte, output last_of_run, input ready);
   modport sink   (input valid, input port_byte, input last_of_run, output ready);
endinterface

FILE: sv/lcdnw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_queue: job queue between front and back
// Small circular buffer of job descriptors with full/empty status.
// ----------------------------------------------------------------------------
module lcdnw_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lcdnw_pkg::job_type          push_job,
   input  logic                      pop,
   output lcdnw_pkg::job_type          head,
   output lcdnw_pkg::queue_status_type status
);

   lcdnw_pkg::job_type              entry_ff [lcdnw_pkg::QUEUE_DEPTH];
   logic [lcdnw_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lcdnw_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lcdnw_pkg::QCNT_W-1:0]    count_ff, count_in;

   function automatic logic [lcdnw_pkg::QPTR_W-1:0] next_ptr(
      logic [lcdnw_pkg::QPTR_W-1:0] p);
      logic [lcdnw_pkg::QPTR_W-1:0] n;
      if (p == lcdnw_pkg::QPTR_W'(lcdnw_pkg::QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == lcdnw_pkg::QCNT_W'(lcdnw_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/lcdnw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_front: command decode and cursor tracking
// Accepts requests, updates the cursor and queues at most one job per request.
// ----------------------------------------------------------------------------
module lcdnw_front (
   input  logic                        clock,
   input  logic                        reset,
   lcdnw_req_if.sink                   req_bus,
   input  lcdnw_pkg::queue_status_type q_status,
   output logic                        push,
   output lcdnw_pkg::job_type          push_job
);

   logic [lcdnw_pkg::COL_W-1:0] col_ff, col_in;
   logic                        line2_ff, line2_in;
   logic                        accept;
   logic                        has_job;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = accept && has_job;

   always_comb begin
      has_job        = 1'b0;
      push_job.kind  = lcdnw_pkg::JOB_BYTE;
      push_job.value = req_bus.data_byte;
      push_job.rs    = 1'b0;
      col_in         = col_ff;
      line2_in       = line2_ff;
      unique case (req_bus.command)
         lcdnw_pkg::CMD_WRITE_CHAR: begin
            push_job.rs = 1'b1;
            if (col_ff >= lcdnw_pkg::COL_W'(lcdnw_pkg::LINE_LENGTH)) begin
               // line 1 full: wrap to line 2; line 2 full: drop
               if (!line2_ff) begin
                  has_job       = 1'b1;
                  push_job.kind = lcdnw_pkg::JOB_WRAP;
                  line2_in      = 1'b1;
                  col_in        = lcdnw_pkg::COL_W'(1);
               end
            end else begin
               has_job = 1'b1;
               col_in  = col_ff + 1'b1;
            end
         end
         lcdnw_pkg::CMD_SET_CURSOR: begin
            if (req_bus.target_line == lcdnw_pkg::LINE_SEL_1) begin
               has_job        = 1'b1;
               push_job.value = lcdnw_pkg::ADDR_LINE1 + {2'b00, req_bus.target_column};
               col_in         = req_bus.target_column;
               line2_in       = 1'b0;
            end else if (req_bus.target_line == lcdnw_pkg::LINE_SEL_2) begin
               has_job        = 1'b1;
               push_job.value = lcdnw_pkg::ADDR_LINE2 + {2'b00, req_bus.target_column};
               col_in         = req_bus.target_column;
               line2_in       = 1'b1;
            end
         end
         lcdnw_pkg::CMD_RAW: begin
            has_job = 1'b1;
         end
         lcdnw_pkg::CMD_INIT: begin
            has_job       = 1'b1;
            push_job.kind = lcdnw_pkg::JOB_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         line2_ff <= 1'b0;
      end else if (accept) begin
         col_ff   <= col_in;
         line2_ff <= line2_in;
      end
   end

endmodule

FILE: sv/lcdnw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_back: port byte sequencer
// Expands each job into nibble strobes, one port byte per cycle while rsp_bus is not stalled.
// ----------------------------------------------------------------------------
module lcdnw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        backlight,
   input  lcdnw_pkg::job_type          head,
   input  lcdnw_pkg::queue_status_type q_status,
   output logic                        pop,
   lcdnw_rsp_if.source                 rsp_bus
);

   logic                          busy_ff, busy_in;
   lcdnw_pkg::job_type            job_ff, cur_job;
   logic [lcdnw_pkg::BIDX_W-1:0]  idx_ff, idx_in, last_idx;
   logic [lcdnw_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_byte_ff, rsp_byte_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          cur_valid, load;
   logic [7:0]                    cur_byte;
   logic                          cur_rs, enable, last_byte, phase_last;
   logic [3:0]                    nibble;

   assign cur_job   = busy_ff ? job_ff : head;
   assign cur_valid = busy_ff || !q_status.empty;
   assign load      = cur_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign pop       = load && !busy_ff;

   always_comb begin
      unique case (cur_job.kind)
         lcdnw_pkg::JOB_INIT: begin
            last_idx = lcdnw_pkg::BIDX_W'(lcdnw_pkg::INIT_LEN - 1);
            cur_byte = lcdnw_pkg::init_byte(idx_ff);
            cur_rs   = 1'b0;
         end
         lcdnw_pkg::JOB_WRAP: begin
            last_idx = lcdnw_pkg::BIDX_W'(1);
            cur_byte = (idx_ff == '0) ? lcdnw_pkg::ADDR_LINE2 : cur_job.value;
            cur_rs   = (idx_ff != '0);
         end
         default: begin
            last_idx = '0;
            cur_byte = cur_job.value;
            cur_rs   = cur_job.rs;
         end
      endcase
   end

   always_comb begin
      nibble      = (phase_ff < lcdnw_pkg::PHASE_W'(lcdnw_pkg::PHASE_HALF)) ?
                    cur_byte[7:4] : cur_byte[3:0];
      enable      = (phase_ff == lcdnw_pkg::PHASE_W'(1)) ||
                    (phase_ff == lcdnw_pkg::PHASE_W'(lcdnw_pkg::PHASE_HALF + 1));
      phase_last  = (phase_ff == lcdnw_pkg::PHASE_W'(lcdnw_pkg::PHASE_COUNT - 1));
      last_byte   = (idx_ff == last_idx);
      rsp_byte_in = {nibble, backlight, enable, 1'b0, cur_rs};
      rsp_last_in = phase_last && last_byte;

      busy_in  = busy_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      if (load) begin
         if (phase_last) begin
            phase_in = '0;
            if (last_byte) begin
               busy_in = 1'b0;
               idx_in  = '0;
            end else begin
               busy_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end else begin
            busy_in  = 1'b1;
            phase_in = phase_ff + 1'b1;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= cur_job;
      end
      if (load) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.port_byte   = rsp_byte_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

endmodule

FILE: sv/char_lcd_nibble_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_core: 4-bit character LCD writer via 8-bit expander
// Turns display commands into expander port bytes with enable strobes.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  req_bus   in   valid/ready        command, data_byte, target_line,
//                                    target_column
//  rsp_bus   out  valid/ready        port_byte, last_of_run
//  csr_*     in   write enable only  backlight_on (1 bit)
//
//  Cycles: one port byte per cycle from the back sequencer; an item gives
//  6 (byte), 12 (wrap plus character) or 42 (init) port bytes, or none.
//  The request side takes a new item each cycle while the two-entry job
//  queue has room, so decode overlaps output of earlier items.
//  Reset: synchronous, clears cursor (line 1, column 0), queue and
//  sequencer; backlight returns to on.
//  Stalls: rsp_bus.ready low holds the output register; the queue then
//  fills and req_bus.ready drops.
//
module char_lcd_nibble_writer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   lcdnw_req_if.sink  req_bus,
   lcdnw_rsp_if.source rsp_bus
);

   // Backlight register, sampled by the sequencer into every port byte
   logic backlight_ff;

   // Job queue links
   logic                        push, pop;
   lcdnw_pkg::job_type          push_job, head;
   lcdnw_pkg::queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b1;
      end else if (csr_write_enable) begin
         backlight_ff <= csr_write_data;
      end
   end

   // Front: decode, cursor bookkeeping, one job per transfer (or none when
   // a character is dropped or the cursor line is invalid)
   lcdnw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // Decoupling queue
   lcdnw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // Back: nibble strobe sequencer with registered output
   lcdnw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .backlight (backlight_ff),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: sv/lcdnw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_checker: port-level checks for the LCD nibble writer
// Watches the response channel and reset behaviour.
// ----------------------------------------------------------------------------
module lcdnw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_port_byte,
   input logic       rsp_last_of_run
);

   // stalled transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_port_byte) &&
                                  $stable(rsp_last_of_run))
      else $error("rsp payload changed while stalled");

   // a run always ends on the enable-clear byte
   a_last_no_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_port_byte[2] |-> !rsp_last_of_run)
      else $error("last_of_run on an enable strobe");

   // unused port bit stays low
   a_spare_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_port_byte[1])
      else $error("spare port bit set");

   // nothing offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind char_lcd_nibble_writer_core lcdnw_checker u_lcdnw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_port_byte   (rsp_bus.port_byte),
   .rsp_last_of_run (rsp_bus.last_of_run)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for char_lcd_nibble_writer_core
// Drives display commands on the request channel and checks every expander
// port byte against an in-bench predictor of the cursor, wrap and nibble
// framing. Runs through the backlight settings and several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;

   // Expander port bit layout
   localparam logic [7:0] PORT_BACKLIGHT = 8'h08;
   localparam logic [7:0] PORT_ENABLE    = 8'h04;
   localparam logic       RS_DATA        = 1'b1;
   localparam logic       RS_COMMAND     = 1'b0;

   // Display init sequence, first byte in the top bits
   localparam int         INIT_BYTES       = 7;
   localparam logic [55:0] DISPLAY_INIT_SEQ = 56'h33_32_06_0C_28_01_02;

   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 50;
   localparam int MAX_REPORTS   = 40;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic [1:0] target_line;
      logic [5:0] target_column;
   } lcd_request_type;

   typedef struct packed {
      logic [7:0] port_byte;
      logic       last_of_run;
   } port_expect_type;

   // ------------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------------
   logic clock            = 1'b0;
   logic reset            = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data   = 1'b0;

   logic       req_valid         = 1'b0;
   logic [1:0] req_command       = '0;
   logic [7:0] req_data_byte     = '0;
   logic [1:0] req_target_line   = '0;
   logic [5:0] req_target_column = '0;
   logic       rsp_ready         = 1'b0;

   lcdnw_req_if req_bus ();
   lcdnw_rsp_if rsp_bus ();

   assign req_bus.valid         = req_valid;
   assign req_bus.command       = req_command;
   assign req_bus.data_byte     = req_data_byte;
   assign req_bus.target_line   = req_target_line;
   assign req_bus.target_column = req_target_column;
   assign rsp_bus.ready         = rsp_ready;

   char_lcd_nibble_writer_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state
   // ------------------------------------------------------------------------
   lcd_request_type request_backlog[$];
   port_expect_type port_expect_q[$];
   logic [7:0]      run_bytes[$];

   logic       backlight_model   = 1'b1;
   logic [5:0] cursor_col_model  = 6'd0;
   logic [1:0] cursor_line_model = lcdnw_pkg::LINE_SEL_1;

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int error_count     = 0;

   // One display byte: high nibble then low, each plain / enable high / enable low
   function automatic void queue_display_byte(logic [7:0] value, logic rs);
      logic [7:0] base;
      logic [3:0] nib;
      int h;
      for (h = 1; h >= 0; h--) begin
         nib  = (h == 1) ? value[7:4] : value[3:0];
         base = {nib, 3'b000, rs};
         if (backlight_model)
            base = base | PORT_BACKLIGHT;
         run_bytes.push_back(base);
         run_bytes.push_back(base | PORT_ENABLE);
         run_bytes.push_back(base & ~PORT_ENABLE);
      end
   endfunction

   // Lines other than 1 and 2 leave everything untouched
   function automatic void move_cursor_to(logic [1:0] line, logic [5:0] col);
      logic [7:0] addr;
      if (line == lcdnw_pkg::LINE_SEL_1)
         addr = lcdnw_pkg::ADDR_LINE1;
      else if (line == lcdnw_pkg::LINE_SEL_2)
         addr = lcdnw_pkg::ADDR_LINE2;
      else
         return;
      queue_display_byte(addr + {2'b00, col}, RS_COMMAND);
      cursor_col_model  = col;
      cursor_line_model = line;
   endfunction

   function automatic void predict_request(lcd_request_type r);
      port_expect_type e;
      int i;
      run_bytes.delete();
      case (r.command)
         lcdnw_pkg::CMD_WRITE_CHAR: begin
            // full line 1 wraps to line 2; full line 2 drops the character
            if (int'(cursor_col_model) < lcdnw_pkg::LINE_LENGTH ||
                cursor_line_model < lcdnw_pkg::LINE_SEL_2) begin
               if (int'(cursor_col_model) >= lcdnw_pkg::LINE_LENGTH)
                  move_cursor_to(cursor_line_model + 2'd1, 6'd0);
               queue_display_byte(r.data_byte, RS_DATA);
               cursor_col_model = cursor_col_model + 6'd1;
            end
         end
         lcdnw_pkg::CMD_SET_CURSOR: move_cursor_to(r.target_line, r.target_column);
         lcdnw_pkg::CMD_RAW:        queue_display_byte(r.data_byte, RS_COMMAND);
         default: begin
            for (i = 0; i < INIT_BYTES; i++)
               queue_display_byte(DISPLAY_INIT_SEQ[8*(INIT_BYTES-1-i) +: 8], RS_COMMAND);
         end
      endcase
      for (i = 0; i < run_bytes.size(); i++) begin
         e.port_byte   = run_bytes[i];
         e.last_of_run = (i == run_bytes.size() - 1);
         port_expect_q.push_back(e);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: predicts on each transfer, then offers the next item
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      lcd_request_type taken;
      lcd_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_bus.ready) begin
         if (req_valid) begin
            taken.command       = req_command;
            taken.data_byte     = req_data_byte;
            taken.target_line   = req_target_line;
            taken.target_column = req_target_column;
            predict_request(taken);
         end
         if (request_backlog.size() != 0 && int'($urandom_range(99)) >= sender_idle_pct) begin
            nxt = request_backlog.pop_front();
            req_valid         <= 1'b1;
            req_command       <= nxt.command;
            req_data_byte     <= nxt.data_byte;
            req_target_line   <= nxt.target_line;
            req_target_column <= nxt.target_column;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Port byte monitor: compares each transfer with the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : port_monitor
      port_expect_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_ready) begin
            if (port_expect_q.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t: unexpected port byte, expected none, actual %h last %b",
                           $time, rsp_bus.port_byte, rsp_bus.last_of_run);
               error_count++;
            end else begin
               want = port_expect_q.pop_front();
               if (rsp_bus.port_byte !== want.port_byte) begin
                  if (error_count < MAX_REPORTS)
                     $display("%0t: port_byte expected %h actual %h",
                              $time, want.port_byte, rsp_bus.port_byte);
                  error_count++;
               end
               if (rsp_bus.last_of_run !== want.last_of_run) begin
                  if (error_count < MAX_REPORTS)
                     $display("%0t: last_of_run expected %b actual %b",
                              $time, want.last_of_run, rsp_bus.last_of_run);
                  error_count++;
               end
            end
         end
         rsp_ready <= (int'($urandom_range(99)) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic push_request(logic [1:0] cmd, logic [7:0] data,
                               logic [1:0] line, logic [5:0] col);
      lcd_request_type r;
      r.command       = cmd;
      r.data_byte     = data;
      r.target_line   = line;
      r.target_column = col;
      request_backlog.push_back(r);
   endtask

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      r.command       = 2'($urandom_range(3));
      r.data_byte     = 8'($urandom_range(255));
      r.target_line   = 2'($urandom_range(3));
      r.target_column = 6'($urandom_range(63));
      return r;
   endfunction

   // Mostly text runs from a cursor near the end of a line, so wrap and drop
   // come up often; the rest is single commands and unconstrained noise.
   task automatic add_random_requests(int n);
      lcd_request_type r;
      int added;
      int run_len;
      int k;
      added = 0;
      while (added < n) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               r = random_request();
               r.command       = lcdnw_pkg::CMD_SET_CURSOR;
               r.target_line   = 2'($urandom_range(1, 2));
               r.target_column = 6'($urandom_range(10, 17));
               request_backlog.push_back(r);
               run_len = int'($urandom_range(3, 12));
               for (k = 0; k < run_len; k++) begin
                  r = random_request();
                  r.command = lcdnw_pkg::CMD_WRITE_CHAR;
                  request_backlog.push_back(r);
               end
               added += run_len + 1;
            end
            3: begin
               r = random_request();
               r.command = lcdnw_pkg::CMD_INIT;
               request_backlog.push_back(r);
               added++;
            end
            4, 5: begin
               request_backlog.push_back(random_request());
               added++;
            end
            default: begin
               r = random_request();
               r.command = ($urandom_range(3) == 0) ? lcdnw_pkg::CMD_RAW :
                                                      lcdnw_pkg::CMD_WRITE_CHAR;
               request_backlog.push_back(r);
               added++;
            end
         endcase
      end
   endtask

   // Idle: nothing left to send and nothing owed, then let dropped items clear
   task automatic wait_drained();
      while (request_backlog.size() != 0 || req_valid || port_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_backlight(logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      backlight_model = value;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: backlight at its reset value, no idling
      push_request(lcdnw_pkg::CMD_INIT,       8'h5A, 2'd3, 6'd63);
      push_request(lcdnw_pkg::CMD_RAW,        8'h00, 2'd0, 6'd0);
      push_request(lcdnw_pkg::CMD_RAW,        8'hFF, 2'd3, 6'd63);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h00, 2'd0, 6'd0);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'hFF, 2'd3, 6'd63);
      // bad lines: no output, cursor kept
      push_request(lcdnw_pkg::CMD_SET_CURSOR, 8'hFF, 2'd0, 6'd5);
      push_request(lcdnw_pkg::CMD_SET_CURSOR, 8'h00, 2'd3, 6'd63);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h41, 2'd0, 6'd0);
      // reach the end of line 1, then wrap
      push_request(lcdnw_pkg::CMD_SET_CURSOR, 8'h00, lcdnw_pkg::LINE_SEL_1, 6'd15);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'hA5, 2'd0, 6'd0);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h5A, 2'd1, 6'd1);
      // line 2 full: character dropped
      push_request(lcdnw_pkg::CMD_SET_CURSOR, 8'hAA, lcdnw_pkg::LINE_SEL_2, 6'd15);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h42, 2'd2, 6'd2);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h43, 2'd0, 6'd0);
      push_request(lcdnw_pkg::CMD_RAW,        8'h01, 2'd1, 6'd12);
      push_request(lcdnw_pkg::CMD_SET_CURSOR, 8'h00, lcdnw_pkg::LINE_SEL_2, 6'd63);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h44, 2'd0, 6'd0);
      // past the end of line 1 by a set cursor
      push_request(lcdnw_pkg::CMD_SET_CURSOR, 8'h00, lcdnw_pkg::LINE_SEL_1, 6'd63);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h45, 2'd0, 6'd0);
      push_request(lcdnw_pkg::CMD_SET_CURSOR, 8'hFF, lcdnw_pkg::LINE_SEL_1, 6'd0);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h7E, 2'd3, 6'd63);
      push_request(lcdnw_pkg::CMD_SET_CURSOR, 8'h00, lcdnw_pkg::LINE_SEL_2, 6'd0);
      push_request(lcdnw_pkg::CMD_WRITE_CHAR, 8'h80, 2'd0, 6'd0);
      wait_drained();

      // Random phases, backlight toggled between each
      write_backlight(1'b0);
      add_random_requests(20);
      wait_drained();

      write_backlight(1'b1);
      sender_idle_pct = 58;
      add_random_requests(10);
      wait_drained();   // sender holds off until every port byte is in
      add_random_requests(10);
      wait_drained();

      write_backlight(1'b0);
      sender_idle_pct = 0;
      stall_pct       = 58;
      add_random_requests(20);
      wait_drained();

      write_backlight(1'b1);
      sender_idle_pct = 9;
      stall_pct       = 9;
      add_random_requests(20);
      wait_drained();

      if (error_count == 0 && port_expect_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
sv/lcdnw_pkg.sv
sv/lcdnw_ifs.sv
sv/lcdnw_queue.sv
sv/lcdnw_front.sv
sv/lcdnw_back.sv
sv/char_lcd_nibble_writer_core.sv
sv/lcdnw_checker.sv
test/testbench.sv
